// File: rtl/chp_pkg.sv
// Shared types, constants and helpers of the container header parser.
// Used by every module under rtl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package chp_pkg;

  typedef enum logic [3:0] {
    PH_HDR,
    PH_HDR_BAD,
    PH_NAME,
    PH_EXT_LEN,
    PH_X_DEV,
    PH_X_CLEN,
    PH_X_CRED,
    PH_X_RLEN,
    PH_X_RP,
    PH_X_SLEN,
    PH_X_STR,
    PH_X_SKIP,
    PH_X_BAD,
    PH_TAIL
  } phase_e;

  typedef struct packed {
    phase_e phase;
    logic   emit;
  } step_t;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TRUNC_HDR = 4'd1;
  localparam logic [3:0] ST_BAD_MAGIC = 4'd2;
  localparam logic [3:0] ST_BAD_VER   = 4'd3;
  localparam logic [3:0] ST_BAD_NAME  = 4'd4;
  localparam logic [3:0] ST_TRUNC_NAM = 4'd5;
  localparam logic [3:0] ST_TRUNC_EXT = 4'd6;
  localparam logic [3:0] ST_BAD_EXTL  = 4'd7;
  localparam logic [3:0] ST_BAD_EXTD  = 4'd8;
  localparam logic [3:0] ST_TRUNC_TL  = 4'd9;
  localparam logic [3:0] ST_MISMATCH  = 4'd10;

  localparam logic [47:0] MAGIC_WORD   = 48'h465753454331;
  localparam logic [15:0] VER_1        = 16'd1;
  localparam logic [15:0] VER_2        = 16'd2;
  localparam int          HDR_OVERHEAD = 60;
  localparam logic [15:0] NAME_MAX     = 16'd256;
  localparam logic [15:0] CRED_MAX     = 16'd512;
  localparam logic [15:0] RP_MAX       = 16'd256;
  localparam logic [15:0] STR_MAX      = 16'd512;
  localparam logic [15:0] EXT_MIN_CRED = 16'd5;
  localparam int          TAIL_BYTES   = 20;
  localparam int          MAC_BYTES    = 32;

  // OR one byte into a little-endian field at byte lane k
  function automatic logic [63:0] take(input logic [63:0] s, input logic [7:0] b,
                                       input logic [2:0] k);
    take = s | ({56'b0, b} << {k, 3'b000});
  endfunction

endpackage

`default_nettype wire

// File: rtl/chp_size_calc.sv
// Expected container size without the payload term: fixed header, name,
// extension, tail, MAC and the tag bytes of all blocks. Uses chp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chp_size_calc #(
  parameter int FIXED_LEN = 3548,
  parameter int EXT_W     = 13
) (
  input  wire logic [15:0]      version_i,
  input  wire logic [8:0]       name_len_i,
  input  wire logic [EXT_W-1:0] ext_total_i,
  input  wire logic [63:0]      blocks_i,
  output logic [69:0]           partial_o
);

  logic [69:0] ext_term;

  always_comb begin
    ext_term = '0;
    if (version_i == chp_pkg::VER_2) begin
      ext_term = 70'(ext_total_i) + 70'(2);
    end
  end

  assign partial_o = 70'(FIXED_LEN) + 70'(name_len_i)
                   + 70'(chp_pkg::TAIL_BYTES + chp_pkg::MAC_BYTES)
                   + ext_term + {2'b00, blocks_i, 4'b0000};

endmodule

`default_nettype wire

// File: rtl/container_header_parser.sv
// Container header parser top level: byte stream in, one status request out.
// Depends on chp_pkg and chp_size_calc.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel: one container byte per request (data_byte_i) with
//   stream_end_i marking the last byte of a container. in_valid_i/in_stall_o.
//   Output channel: exactly one status request per container, carrying the
//   captured header fields. out_valid_o, held while out_stall_i is high.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 file length, 1 password auth code); write only while idle.
// Throughput and timing
//   One byte per cycle while the input is not stalled. Each byte updates the parse state in the cycle it is
//   accepted; a result shows on the output register in the cycle after the byte
//   that causes it. The size check splits into two adds: the block-tag sum is
//   registered at the block size field, the payload add at the last tail byte.
// Stall
//   Input stalls only while a result is held and the receiver stalls; bytes
//   keep flowing while the output is empty or being taken.
// Reset
//   Async reset clears the configuration registers, parse state and the output valid. After a
//   result, bytes are dropped through the one with stream_end_i set.

module container_header_parser #(
  parameter int KEM_CT_BYTES  = 1088,
  parameter int KEM_SK_BYTES  = 2400,
  parameter int MAX_EXT_BYTES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [62:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        stream_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       status_o,
  output logic [15:0]      format_version_o,
  output logic [7:0]       auth_kind_o,
  output logic [7:0]       device_kind_o,
  output logic [31:0]      kdf_passes_o,
  output logic [31:0]      kdf_memory_o,
  output logic [31:0]      kdf_lanes_o,
  output logic [8:0]       name_length_o,
  output logic [63:0]      block_count_o,
  output logic [31:0]      block_bytes_o,
  output logic [63:0]      payload_bytes_o
);

  localparam int FIXED_HDR_LEN = chp_pkg::HDR_OVERHEAD + KEM_CT_BYTES + KEM_SK_BYTES;
  localparam int CNT_W         = $clog2(FIXED_HDR_LEN);
  localparam int EXT_W         = $clog2(MAX_EXT_BYTES + 1);

  localparam logic [CNT_W-1:0] POS_NLEN0 = CNT_W'(FIXED_HDR_LEN - 2);
  localparam logic [CNT_W-1:0] POS_NLEN1 = CNT_W'(FIXED_HDR_LEN - 1);

  // configuration
  logic [62:0] file_len_q;
  logic [7:0]  pw_code_q;

  // parse state
  chp_pkg::phase_e  phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [63:0]      shift_q, shift_d;
  logic [EXT_W-1:0] rem_q, rem_d;
  logic [9:0]       sub_q, sub_d;
  logic [1:0]       idx_q, idx_d;
  logic [EXT_W-1:0] ext_total_q, ext_total_d;
  logic             fin_q, fin_d;
  logic [15:0]      ver_q, ver_d;
  logic [7:0]       auth_q, auth_d;
  logic [7:0]       dev_q, dev_d;
  logic [31:0]      passes_q, passes_d;
  logic [31:0]      memory_q, memory_d;
  logic [31:0]      lanes_q, lanes_d;
  logic [8:0]       name_q, name_d;
  logic [63:0]      blocks_q, blocks_d;
  logic [31:0]      bsize_q, bsize_d;
  logic [69:0]      part_q, part_d;
  logic [69:0]      part_calc;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [3:0]  status_q;
  logic [15:0] res_ver_q;
  logic [7:0]  res_auth_q, res_dev_q;
  logic [31:0] res_passes_q, res_memory_q, res_lanes_q, res_bsize_q;
  logic [8:0]  res_name_q;
  logic [63:0] res_blocks_q, res_payload_q;

  logic        acc;
  logic        emit;
  logic [3:0]  st;
  logic [63:0] payload_v;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign acc        = in_valid_i & ~in_stall_o;

  chp_size_calc #(
    .FIXED_LEN(FIXED_HDR_LEN),
    .EXT_W    (EXT_W)
  ) u_size (
    .version_i  (ver_q),
    .name_len_i (name_q),
    .ext_total_i(ext_total_q),
    .blocks_i   (blocks_q),
    .partial_o  (part_calc)
  );

  // Bad extension data: report at once when the blob is used up, else drain it.
  function automatic chp_pkg::step_t go_bad(input logic [EXT_W-1:0] rem);
    chp_pkg::step_t s;
    s.emit  = (rem == '0);
    s.phase = chp_pkg::PH_X_BAD;
    return s;
  endfunction

  function automatic chp_pkg::step_t strings_start(input logic [EXT_W-1:0] rem,
                                                   input logic [1:0] idx);
    chp_pkg::step_t s;
    s.emit  = 1'b0;
    if (rem == '0) begin
      s.phase = chp_pkg::PH_TAIL;
    end else if (idx == 2'd3) begin
      s.phase = chp_pkg::PH_X_SKIP;
    end else if (rem < EXT_W'(2)) begin
      s = go_bad(rem);
    end else begin
      s.phase = chp_pkg::PH_X_SLEN;
    end
    return s;
  endfunction

  always_comb begin
    logic [CNT_W-1:0] r;
    logic [63:0]      sh;
    logic [15:0]      len;
    logic [15:0]      limit;
    logic [EXT_W-1:0] rem_dec;
    logic [9:0]       sub_dec;
    logic [69:0]      total;
    logic             step_en;
    logic             sdone;
    chp_pkg::phase_e  which;
    chp_pkg::step_t   stp;

    phase_d     = phase_q;
    cnt_d       = cnt_q;
    shift_d     = shift_q;
    rem_d       = rem_q;
    sub_d       = sub_q;
    idx_d       = idx_q;
    ext_total_d = ext_total_q;
    fin_d       = fin_q;
    ver_d       = ver_q;
    auth_d      = auth_q;
    dev_d       = dev_q;
    passes_d    = passes_q;
    memory_d    = memory_q;
    lanes_d     = lanes_q;
    name_d      = name_q;
    blocks_d    = blocks_q;
    bsize_d     = bsize_q;
    part_d      = part_q;
    emit        = 1'b0;
    st          = chp_pkg::ST_OK;
    payload_v   = '0;
    r           = '0;
    sh          = '0;
    len         = '0;
    limit       = '0;
    total       = '0;
    step_en     = 1'b0;
    sdone       = 1'b0;
    which       = phase_q;
    stp         = '{phase: phase_q, emit: 1'b0};
    rem_dec     = (rem_q != '0) ? rem_q - EXT_W'(1) : rem_q;
    sub_dec     = (sub_q != '0) ? sub_q - 10'd1 : sub_q;

    if (acc && !fin_q) begin
      case (phase_q)
        chp_pkg::PH_HDR, chp_pkg::PH_HDR_BAD: begin
          cnt_d = cnt_q + CNT_W'(1);
          if (cnt_q < CNT_W'(6)) begin
            shift_d = {shift_q[55:0], data_byte_i};
            if (cnt_q == CNT_W'(5)) begin
              shift_d = '0;
              if ({shift_q[39:0], data_byte_i} != chp_pkg::MAGIC_WORD) begin
                emit = 1'b1;
                st   = chp_pkg::ST_BAD_MAGIC;
              end
            end
          end else if (cnt_q == CNT_W'(6)) begin
            shift_d = {56'b0, data_byte_i};
          end else if (cnt_q == CNT_W'(7)) begin
            ver_d   = {data_byte_i, shift_q[7:0]};
            shift_d = '0;
          end else if (cnt_q == CNT_W'(8)) begin
            auth_d = data_byte_i;
          end else if (cnt_q >= CNT_W'(10) && cnt_q <= CNT_W'(13)) begin
            r       = cnt_q - CNT_W'(10);
            sh      = chp_pkg::take(shift_q, data_byte_i, r[2:0]);
            shift_d = sh;
            if (cnt_q == CNT_W'(13)) begin
              shift_d = '0;
              if ((ver_q != chp_pkg::VER_1 && ver_q != chp_pkg::VER_2) ||
                  sh != 64'(FIXED_HDR_LEN)) begin
                phase_d = chp_pkg::PH_HDR_BAD;
              end
            end
          end else if (cnt_q >= CNT_W'(30) && cnt_q <= CNT_W'(41)) begin
            if (phase_q == chp_pkg::PH_HDR) begin
              r       = cnt_q - CNT_W'(30);
              sh      = chp_pkg::take(shift_q, data_byte_i, {1'b0, r[1:0]});
              shift_d = sh;
              if (r[1:0] == 2'd3) begin
                shift_d = '0;
                case (r[3:2])
                  2'd0:    passes_d = sh[31:0];
                  2'd1:    memory_d = sh[31:0];
                  default: lanes_d  = sh[31:0];
                endcase
              end
            end
          end else if (cnt_q >= POS_NLEN0) begin
            sh      = chp_pkg::take(shift_q, data_byte_i, {2'b00, cnt_q == POS_NLEN1});
            shift_d = sh;
            if (cnt_q == POS_NLEN1) begin
              shift_d = '0;
              if (phase_q == chp_pkg::PH_HDR_BAD) begin
                emit = 1'b1;
                st   = chp_pkg::ST_BAD_VER;
              end else if (sh[15:0] > chp_pkg::NAME_MAX) begin
                emit = 1'b1;
                st   = chp_pkg::ST_BAD_NAME;
              end else begin
                name_d = sh[8:0];
                sub_d  = sh[9:0];
                if (sh[9:0] == '0) begin
                  phase_d = (ver_q == chp_pkg::VER_2) ? chp_pkg::PH_EXT_LEN
                                                      : chp_pkg::PH_TAIL;
                  cnt_d   = '0;
                end else begin
                  phase_d = chp_pkg::PH_NAME;
                end
              end
            end
          end
        end
        chp_pkg::PH_NAME: begin
          sub_d = sub_dec;
          if (sub_dec == '0) begin
            phase_d = (ver_q == chp_pkg::VER_2) ? chp_pkg::PH_EXT_LEN : chp_pkg::PH_TAIL;
            cnt_d   = '0;
            shift_d = '0;
          end
        end
        chp_pkg::PH_EXT_LEN: begin
          sh      = chp_pkg::take(shift_q, data_byte_i, {2'b00, cnt_q[0]});
          shift_d = sh;
          cnt_d   = cnt_q + CNT_W'(1);
          if (cnt_q[0]) begin
            len     = sh[15:0];
            cnt_d   = '0;
            shift_d = '0;
            if (len > 16'(MAX_EXT_BYTES)) begin
              emit = 1'b1;
              st   = chp_pkg::ST_BAD_EXTL;
            end else begin
              ext_total_d = EXT_W'(len);
              rem_d       = EXT_W'(len);
              if (len == '0) begin
                phase_d = chp_pkg::PH_TAIL;
              end else if (auth_q != pw_code_q) begin
                if (len < chp_pkg::EXT_MIN_CRED) begin
                  stp     = go_bad(EXT_W'(len));
                  step_en = 1'b1;
                end else begin
                  phase_d = chp_pkg::PH_X_DEV;
                end
              end else begin
                idx_d   = '0;
                stp     = strings_start(EXT_W'(len), 2'd0);
                step_en = 1'b1;
              end
            end
          end
        end
        chp_pkg::PH_X_DEV: begin
          rem_d   = rem_dec;
          dev_d   = data_byte_i;
          phase_d = chp_pkg::PH_X_CLEN;
          cnt_d   = '0;
          shift_d = '0;
        end
        chp_pkg::PH_X_CLEN, chp_pkg::PH_X_RLEN, chp_pkg::PH_X_SLEN: begin
          rem_d   = rem_dec;
          sh      = chp_pkg::take(shift_q, data_byte_i, {2'b00, cnt_q[0]});
          shift_d = sh;
          cnt_d   = cnt_q + CNT_W'(1);
          if (cnt_q[0]) begin
            len     = sh[15:0];
            cnt_d   = '0;
            shift_d = '0;
            case (phase_q)
              chp_pkg::PH_X_CLEN: begin
                limit = chp_pkg::CRED_MAX;
                which = chp_pkg::PH_X_CRED;
              end
              chp_pkg::PH_X_RLEN: begin
                limit = chp_pkg::RP_MAX;
                which = chp_pkg::PH_X_RP;
              end
              default: begin
                limit = chp_pkg::STR_MAX;
                which = chp_pkg::PH_X_STR;
              end
            endcase
            if (len > limit || 16'(rem_dec) < len) begin
              stp     = go_bad(rem_dec);
              step_en = 1'b1;
            end else begin
              sub_d = len[9:0];
              if (len != '0) begin
                phase_d = which;
              end else begin
                sdone = 1'b1;
              end
            end
          end
        end
        chp_pkg::PH_X_CRED, chp_pkg::PH_X_RP, chp_pkg::PH_X_STR: begin
          rem_d = rem_dec;
          sub_d = sub_dec;
          if (sub_dec == '0) begin
            which = phase_q;
            sdone = 1'b1;
          end
        end
        chp_pkg::PH_X_SKIP: begin
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = chp_pkg::PH_TAIL;
            cnt_d   = '0;
            shift_d = '0;
          end
        end
        chp_pkg::PH_X_BAD: begin
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            emit = 1'b1;
            st   = chp_pkg::ST_BAD_EXTD;
          end
        end
        chp_pkg::PH_TAIL: begin
          cnt_d = cnt_q + CNT_W'(1);
          if (cnt_q < CNT_W'(12)) begin
            r = cnt_q;
          end else begin
            r = cnt_q - CNT_W'(12);
          end
          sh      = chp_pkg::take(shift_q, data_byte_i, r[2:0]);
          shift_d = sh;
          if (cnt_q == CNT_W'(7)) begin
            blocks_d = sh;
            shift_d  = '0;
          end else if (cnt_q == CNT_W'(11)) begin
            bsize_d = sh[31:0];
            shift_d = '0;
            part_d  = part_calc;
          end else if (cnt_q == CNT_W'(chp_pkg::TAIL_BYTES - 1)) begin
            shift_d   = '0;
            payload_v = sh;
            total     = part_q + 70'(sh);
            emit      = 1'b1;
            st        = (total == 70'(file_len_q)) ? chp_pkg::ST_OK : chp_pkg::ST_MISMATCH;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase

      // end of a skipped sub-field inside the extension blob
      if (sdone) begin
        step_en = 1'b1;
        case (which)
          chp_pkg::PH_X_CRED: begin
            if (rem_dec < EXT_W'(2)) begin
              stp = go_bad(rem_dec);
            end else begin
              stp = '{phase: chp_pkg::PH_X_RLEN, emit: 1'b0};
            end
          end
          chp_pkg::PH_X_RP: begin
            idx_d = '0;
            stp   = strings_start(rem_dec, 2'd0);
          end
          default: begin
            idx_d = idx_q + 2'd1;
            stp   = strings_start(rem_dec, idx_q + 2'd1);
          end
        endcase
      end

      if (step_en) begin
        phase_d = stp.phase;
        cnt_d   = '0;
        shift_d = '0;
        if (stp.emit) begin
          emit = 1'b1;
          st   = chp_pkg::ST_BAD_EXTD;
        end
      end

      if (emit) begin
        fin_d = 1'b1;
      end
    end

    // last byte: report truncation of the open section, then start over
    if (acc && stream_end_i) begin
      if (!fin_q && !emit) begin
        emit = 1'b1;
        case (phase_d)
          chp_pkg::PH_HDR, chp_pkg::PH_HDR_BAD: st = chp_pkg::ST_TRUNC_HDR;
          chp_pkg::PH_NAME:                     st = chp_pkg::ST_TRUNC_NAM;
          chp_pkg::PH_TAIL:                     st = chp_pkg::ST_TRUNC_TL;
          default:                              st = chp_pkg::ST_TRUNC_EXT;
        endcase
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_len_q <= '0;
      pw_code_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        1'b0:    file_len_q <= cfg_data_i;
        default: pw_code_q  <= cfg_data_i[7:0];
      endcase
    end
  end

  // parse state; the last byte of a container clears everything
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= chp_pkg::PH_HDR;
      cnt_q       <= '0;
      shift_q     <= '0;
      rem_q       <= '0;
      sub_q       <= '0;
      idx_q       <= '0;
      ext_total_q <= '0;
      fin_q       <= 1'b0;
      ver_q       <= '0;
      auth_q      <= '0;
      dev_q       <= '0;
      passes_q    <= '0;
      memory_q    <= '0;
      lanes_q     <= '0;
      name_q      <= '0;
      blocks_q    <= '0;
      bsize_q     <= '0;
      part_q      <= '0;
    end else if (acc && stream_end_i) begin
      phase_q     <= chp_pkg::PH_HDR;
      cnt_q       <= '0;
      shift_q     <= '0;
      rem_q       <= '0;
      sub_q       <= '0;
      idx_q       <= '0;
      ext_total_q <= '0;
      fin_q       <= 1'b0;
      ver_q       <= '0;
      auth_q      <= '0;
      dev_q       <= '0;
      passes_q    <= '0;
      memory_q    <= '0;
      lanes_q     <= '0;
      name_q      <= '0;
      blocks_q    <= '0;
      bsize_q     <= '0;
      part_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      shift_q     <= shift_d;
      rem_q       <= rem_d;
      sub_q       <= sub_d;
      idx_q       <= idx_d;
      ext_total_q <= ext_total_d;
      fin_q       <= fin_d;
      ver_q       <= ver_d;
      auth_q      <= auth_d;
      dev_q       <= dev_d;
      passes_q    <= passes_d;
      memory_q    <= memory_d;
      lanes_q     <= lanes_d;
      name_q      <= name_d;
      blocks_q    <= blocks_d;
      bsize_q     <= bsize_d;
      part_q      <= part_d;
    end
  end

  // result register: load on emit, drop when the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (acc && emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && emit) begin
      status_q      <= st;
      res_ver_q     <= ver_d;
      res_auth_q    <= auth_d;
      res_dev_q     <= dev_d;
      res_passes_q  <= passes_d;
      res_memory_q  <= memory_d;
      res_lanes_q   <= lanes_d;
      res_name_q    <= name_d;
      res_blocks_q  <= blocks_d;
      res_bsize_q   <= bsize_d;
      res_payload_q <= payload_v;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign format_version_o = res_ver_q;
  assign auth_kind_o      = res_auth_q;
  assign device_kind_o    = res_dev_q;
  assign kdf_passes_o     = res_passes_q;
  assign kdf_memory_o     = res_memory_q;
  assign kdf_lanes_o      = res_lanes_q;
  assign name_length_o    = res_name_q;
  assign block_count_o    = res_blocks_q;
  assign block_bytes_o    = res_bsize_q;
  assign payload_bytes_o  = res_payload_q;

endmodule

`default_nettype wire

// File: rtl/chp_checker.sv
// Port-level checker of the container header parser and its bind.
// Depends on chp_pkg; attaches to container_header_parser.
`timescale 1ns / 1ps
`default_nettype none

module chp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [3:0]  status_o,
  input wire logic [15:0] format_version_o
);

  // hold a stalled request
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_hold_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o))
    else $error("stalled status changed");

  // input stalls only while a held result is stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= chp_pkg::ST_MISMATCH)
    else $error("status code out of range");

  a_ok_version: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == chp_pkg::ST_OK |->
      format_version_o == chp_pkg::VER_1 || format_version_o == chp_pkg::VER_2)
    else $error("ok status with unchecked version");

endmodule

bind container_header_parser chp_checker u_chp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .format_version_o(format_version_o)
);

`default_nettype wire

// File: tb/tb_container_header_parser.sv
// Self-checking bench for container_header_parser: builds byte-level containers,
// predicts one status request per container and checks it against the block.
// Depends on rtl/chp_pkg.sv and rtl/container_header_parser.sv.
`timescale 1ns / 1ps

module tb_container_header_parser;
  import chp_pkg::*;

  localparam int CT_BYTES  = 1088;
  localparam int SK_BYTES  = 2400;
  localparam int EXT_MAX   = 4096;
  localparam int HDR_LEN   = HDR_OVERHEAD + CT_BYTES + SK_BYTES;
  localparam int IDLE_MAX  = 20000;
  localparam int HOLD_LEN  = 2000;
  localparam int RAND_RESULTS = 60;

  localparam logic CFG_FILE_LEN = 1'b0;
  localparam logic CFG_PWD_CODE = 1'b1;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] version;
    logic [7:0]  auth;
    logic [7:0]  device;
    logic [31:0] passes;
    logic [31:0] memory;
    logic [31:0] lanes;
    logic [8:0]  nlen;
    logic [63:0] blocks;
    logic [31:0] bsize;
    logic [63:0] payload;
  } header_rec_t;

  // Shape of one generated container
  typedef struct {
    int          noise_len;   // >0: short random stream instead of a container
    logic [15:0] ver;
    bit          magic_bad;
    bit          hlen_bad;
    logic [15:0] nlen;
    logic [7:0]  auth;
    int          blob_len;    // >=0: raw random blob of this size
    bit          cred_cut;
    int          nstr;
    int          leftover;
    int          lim_bad;     // 1 credential, 2 relying party, 3 first string
    int          ext_skew;
    bit          ext_forced;
    logic [15:0] ext_force;
    logic [63:0] blocks;
    logic [63:0] payload;
    int          cut;         // -1 whole, -2 random, else last index kept
    int          drop;        // bytes removed from the end
    int          junk;        // ignored bytes appended after the container
  } shape_t;

  // Predicts the header status per container and checks results in order
  class status_board;
    header_rec_t want_q[$];
    int          fails;
    logic [62:0] file_len;
    logic [7:0]  pwd_code;
    phase_e      ph;
    int unsigned sec, ext_rem, sub_len, ext_tot, str_idx;
    logic [63:0] shift;
    logic [63:0] cap[9];
    bit          done;

    function new();
      fails = 0;
      file_len = '0;
      pwd_code = '0;
      clear();
    endfunction

    function void clear();
      ph = PH_HDR;
      sec = 0; shift = '0; ext_rem = 0; sub_len = 0; str_idx = 0; ext_tot = 0;
      foreach (cap[i]) cap[i] = '0;
      done = 0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function void push_status(logic [3:0] st);
      header_rec_t r;
      r.status  = st;
      r.version = cap[0][15:0];
      r.auth    = cap[1][7:0];
      r.device  = cap[1][15:8];
      r.passes  = cap[2][31:0];
      r.memory  = cap[3][31:0];
      r.lanes   = cap[4][31:0];
      r.nlen    = cap[5][8:0];
      r.blocks  = cap[6];
      r.bsize   = cap[7][31:0];
      r.payload = cap[8];
      want_q.insert(want_q.size(), r);
      done = 1;
    endfunction

    function void lane_or(logic [7:0] b, int unsigned k);
      shift |= {56'b0, b} << (8 * (k & 7));
    endfunction

    function void start_tail();
      ph = PH_TAIL; sec = 0; shift = '0;
    endfunction

    function void ext_bad();
      if (ext_rem == 0) push_status(ST_BAD_EXTD);
      else ph = PH_X_BAD;
    endfunction

    function void start_strings();
      if (ext_rem == 0) start_tail();
      else if (str_idx >= 3) ph = PH_X_SKIP;
      else if (ext_rem < 2) ext_bad();
      else begin
        ph = PH_X_SLEN; sec = 0; shift = '0;
      end
    endfunction

    function void field_done(phase_e which);
      if (which == PH_X_CRED) begin
        if (ext_rem < 2) ext_bad();
        else begin
          ph = PH_X_RLEN; sec = 0; shift = '0;
        end
        return;
      end
      if (which == PH_X_RP) str_idx = 0;
      else str_idx = (str_idx + 1) & 3;
      start_strings();
    endfunction

    function void name_done();
      if (cap[0] == 64'd2) begin
        ph = PH_EXT_LEN; sec = 0; shift = '0;
      end else start_tail();
    endfunction

    function void hdr_byte(logic [7:0] b);
      int unsigned pos, r;
      logic [63:0] v;
      pos = sec;
      sec++;
      if (pos < 6) begin
        shift = (shift << 8) | {56'b0, b};
        if (pos == 5) begin
          v = shift;
          shift = '0;
          if (v != {16'b0, MAGIC_WORD}) push_status(ST_BAD_MAGIC);
        end
      end else if (pos == 6) shift = {56'b0, b};
      else if (pos == 7) begin
        cap[0] = shift | ({56'b0, b} << 8);
        shift = '0;
      end else if (pos == 8) cap[1] = {56'b0, b};
      else if (pos >= 10 && pos <= 13) begin
        lane_or(b, pos - 10);
        if (pos == 13) begin
          if ((cap[0] != 1 && cap[0] != 2) || shift != HDR_LEN) ph = PH_HDR_BAD;
          shift = '0;
        end
      end else if (pos >= 30 && pos <= 41) begin
        if (ph == PH_HDR) begin
          r = pos - 30;
          lane_or(b, r & 3);
          if ((r & 3) == 3) begin
            cap[2 + r / 4] = shift;
            shift = '0;
          end
        end
      end else if (pos >= HDR_LEN - 2) begin
        lane_or(b, pos - (HDR_LEN - 2));
        if (pos == HDR_LEN - 1) begin
          v = shift;
          shift = '0;
          if (ph == PH_HDR_BAD) push_status(ST_BAD_VER);
          else if (v > NAME_MAX) push_status(ST_BAD_NAME);
          else begin
            cap[5] = v;
            sub_len = v;
            if (sub_len == 0) name_done();
            else ph = PH_NAME;
          end
        end
      end
    endfunction

    function void ext_len_byte(logic [7:0] b);
      logic [63:0] len;
      lane_or(b, sec);
      sec++;
      if (sec < 2) return;
      len = shift; shift = '0; sec = 0;
      if (len > EXT_MAX) begin
        push_status(ST_BAD_EXTL);
        return;
      end
      ext_tot = len;
      ext_rem = len;
      if (len == 0) start_tail();
      else if (cap[1][7:0] != pwd_code) begin
        if (len < EXT_MIN_CRED) ext_bad();
        else ph = PH_X_DEV;
      end else begin
        str_idx = 0;
        start_strings();
      end
    endfunction

    function void ext_byte(logic [7:0] b);
      logic [63:0] len, lim;
      if (ext_rem > 0) ext_rem--;
      case (ph)
        PH_X_DEV: begin
          cap[1] |= {56'b0, b} << 8;
          ph = PH_X_CLEN; sec = 0; shift = '0;
        end
        PH_X_CLEN, PH_X_RLEN, PH_X_SLEN: begin
          lane_or(b, sec);
          sec++;
          if (sec >= 2) begin
            len = shift; shift = '0; sec = 0;
            lim = (ph == PH_X_RLEN) ? RP_MAX : ((ph == PH_X_CLEN) ? CRED_MAX : STR_MAX);
            if (len > lim || ext_rem < len) ext_bad();
            else begin
              sub_len = len;
              if (len != 0) ph = phase_e'(ph + 1);
              else field_done(phase_e'(ph + 1));
            end
          end
        end
        PH_X_CRED, PH_X_RP, PH_X_STR: begin
          if (sub_len > 0) sub_len--;
          if (sub_len == 0) field_done(ph);
        end
        PH_X_SKIP: if (ext_rem == 0) start_tail();
        default: if (ext_rem == 0) push_status(ST_BAD_EXTD);
      endcase
    endfunction

    function void tail_byte(logic [7:0] b);
      int unsigned pos;
      logic [63:0] base, sum;
      pos = sec;
      sec++;
      if (pos < 8) begin
        lane_or(b, pos);
        if (pos == 7) begin cap[6] = shift; shift = '0; end
        return;
      end
      if (pos < 12) begin
        lane_or(b, pos - 8);
        if (pos == 11) begin cap[7] = shift; shift = '0; end
        return;
      end
      lane_or(b, pos - 12);
      if (pos < TAIL_BYTES - 1) return;
      cap[8] = shift;
      shift = '0;
      base = HDR_LEN + cap[5] + TAIL_BYTES + MAC_BYTES;
      if (cap[0] == 64'd2) base += 2 + ext_tot;
      // no wrap: either add overflowing 64 bits is a mismatch
      if (cap[8] > ~64'd0 - base) begin
        push_status(ST_MISMATCH);
        return;
      end
      sum = base + cap[8];
      if (cap[6] > (~64'd0 - sum) / 16) begin
        push_status(ST_MISMATCH);
        return;
      end
      sum += cap[6] * 16;
      push_status((sum == {1'b0, file_len}) ? ST_OK : ST_MISMATCH);
    endfunction

    function logic [3:0] cut_status();
      case (ph)
        PH_HDR, PH_HDR_BAD: return ST_TRUNC_HDR;
        PH_NAME:            return ST_TRUNC_NAM;
        PH_TAIL:            return ST_TRUNC_TL;
        default:            return ST_TRUNC_EXT;
      endcase
    endfunction

    // Note one accepted byte request
    function void note(logic [7:0] b, logic e);
      if (!done) begin
        case (ph)
          PH_HDR, PH_HDR_BAD: hdr_byte(b);
          PH_NAME: begin
            if (sub_len > 0) sub_len--;
            if (sub_len == 0) name_done();
          end
          PH_EXT_LEN: ext_len_byte(b);
          PH_TAIL:    tail_byte(b);
          default:    ext_byte(b);
        endcase
      end
      if (e) begin
        if (!done) push_status(cut_status());
        clear();
      end
    endfunction

    function void cmp(string name, logic [63:0] w, logic [63:0] g);
      if (w !== g) begin
        $error("%s: expected %0h, actual %0h", name, w, g);
        fails++;
      end
    endfunction

    // Check one accepted status request against the oldest prediction
    function void check(header_rec_t g);
      header_rec_t w;
      if (want_q.size() == 0) begin
        $error("status request with none pending, status %0d", g.status);
        fails++;
        return;
      end
      w = want_q.pop_front();
      cmp("status", w.status, g.status);
      cmp("format_version", w.version, g.version);
      cmp("auth_kind", w.auth, g.auth);
      cmp("device_kind", w.device, g.device);
      cmp("kdf_passes", w.passes, g.passes);
      cmp("kdf_memory", w.memory, g.memory);
      cmp("kdf_lanes", w.lanes, g.lanes);
      cmp("name_length", w.nlen, g.nlen);
      cmp("block_count", w.blocks, g.blocks);
      cmp("block_bytes", w.bsize, g.bsize);
      cmp("payload_bytes", w.payload, g.payload);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [62:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        stream_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  status_o;
  logic [15:0] format_version_o;
  logic [7:0]  auth_kind_o, device_kind_o;
  logic [31:0] kdf_passes_o, kdf_memory_o, kdf_lanes_o, block_bytes_o;
  logic [8:0]  name_length_o;
  logic [63:0] block_count_o, payload_bytes_o;

  container_header_parser dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .data_byte_i, .stream_end_i,
    .out_valid_o, .out_stall_i, .status_o, .format_version_o,
    .auth_kind_o, .device_kind_o, .kdf_passes_o, .kdf_memory_o,
    .kdf_lanes_o, .name_length_o, .block_count_o, .block_bytes_o,
    .payload_bytes_o
  );

  always #6 clk_i = ~clk_i;

  status_board sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 0;
  int  hold_cnt = 0;
  int  burst_cnt = 0;
  int  idle_cycles = 0;
  logic [7:0] pwd_now = '0;

  // Receiver: random stalls, occasional bursts, one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      out_stall_i = 1'b1;
      hold_cnt--;
    end else if (hold_req) begin
      hold_req = 0;
      hold_cnt = HOLD_LEN;
      out_stall_i = 1'b1;
    end else if (burst_cnt > 0) begin
      out_stall_i = 1'b1;
      burst_cnt--;
    end else if (recv_stall_pct > 0 && $urandom_range(0, 199) == 0) begin
      burst_cnt = $urandom_range(10, 40);
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Sample results at the rising edge
  always @(posedge clk_i) begin
    header_rec_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status  = status_o;
      got.version = format_version_o;
      got.auth    = auth_kind_o;
      got.device  = device_kind_o;
      got.passes  = kdf_passes_o;
      got.memory  = kdf_memory_o;
      got.lanes   = kdf_lanes_o;
      got.nlen    = name_length_o;
      got.blocks  = block_count_o;
      got.bsize   = block_bytes_o;
      got.payload = payload_bytes_o;
      sb.check(got);
    end
  end

  // Watchdog: end the run after too many cycles with no request moving
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IDLE_MAX) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= send_idle_pct) return 0;
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(logic [7:0] b, logic e);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    data_byte_i = b;
    stream_end_i = e;
    do @(posedge clk_i); while (in_stall_o);
    sb.note(b, e);
  endtask

  task automatic send_stream(ref logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [62:0] d);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = d;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_FILE_LEN) sb.file_len = d;
    else sb.pwd_code = d[7:0];
  endtask

  function automatic void put_le(ref logic [7:0] q[$], input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) q.insert(q.size(), v[8*i +: 8]);
  endfunction

  function automatic void put_rand(ref logic [7:0] q[$], input int n);
    for (int i = 0; i < n; i++) q.insert(q.size(), 8'($urandom_range(0, 255)));
  endfunction

  function automatic shape_t clean_shape();
    shape_t s;
    s.noise_len = 0;
    s.ver = $urandom_range(0, 1) ? VER_1 : VER_2;
    s.magic_bad = 0;
    s.hlen_bad = 0;
    s.nlen = ($urandom_range(0, 19) == 0) ? NAME_MAX : 16'($urandom_range(0, 12));
    s.auth = $urandom_range(0, 1) ? pwd_now : 8'($urandom_range(0, 255));
    s.blob_len = ($urandom_range(0, 9) == 0) ? 0 : -1;
    s.cred_cut = 0;
    s.nstr = $urandom_range(0, 4);
    s.leftover = (s.nstr >= 3) ? $urandom_range(0, 3) : 0;
    s.lim_bad = 0;
    s.ext_skew = 0;
    s.ext_forced = 0;
    s.ext_force = '0;
    s.blocks = $urandom_range(0, 1000);
    s.payload = $urandom_range(0, 100000);
    s.cut = -1;
    s.drop = 0;
    s.junk = 0;
    return s;
  endfunction

  // Build the byte stream of one container; size is the length it claims
  function automatic void build(input shape_t s, ref logic [7:0] q[$],
                                output logic [63:0] size);
    logic [7:0] blob[$];
    logic [63:0] len;
    int n, elen;
    q.delete();
    size = '0;
    if (s.noise_len > 0) begin
      // half start with a true magic prefix of random length, possibly empty
      n = $urandom_range(0, 1) ? $urandom_range(0, 6) : 0;
      for (int i = 0; i < n && i < s.noise_len; i++)
        q.insert(q.size(), MAGIC_WORD[47 - 8*i -: 8]);
      put_rand(q, s.noise_len - q.size());
      return;
    end
    for (int i = 0; i < 6; i++) q.insert(q.size(), MAGIC_WORD[47 - 8*i -: 8]);
    if (s.magic_bad) q[$urandom_range(0, 5)] ^= 8'($urandom_range(1, 255));
    put_le(q, s.ver, 2);
    q.insert(q.size(), s.auth);
    put_rand(q, 1);
    put_le(q, s.hlen_bad ? (HDR_LEN ^ (64'd1 << $urandom_range(0, 31))) : HDR_LEN, 4);
    put_rand(q, 16 + 12 + (HDR_LEN - 2 - 42));
    put_le(q, s.nlen, 2);
    if (s.nlen <= NAME_MAX) put_rand(q, s.nlen);
    elen = 0;
    if (s.ver == VER_2) begin
      if (s.blob_len >= 0) put_rand(blob, s.blob_len);
      else begin
        if (s.auth != pwd_now) begin
          put_rand(blob, 1);
          len = (s.lim_bad == 1) ? 64'($urandom_range(513, 65535)) : 64'($urandom_range(0, 12));
          put_le(blob, len, 2);
          put_rand(blob, (len > CRED_MAX) ? 2 : len);
          if (s.cred_cut) put_rand(blob, $urandom_range(0, 1));
          else begin
            len = (s.lim_bad == 2) ? 64'($urandom_range(257, 65535)) : 64'($urandom_range(0, 8));
            put_le(blob, len, 2);
            put_rand(blob, (len > RP_MAX) ? 2 : len);
          end
        end
        if (!s.cred_cut) begin
          for (int i = 0; i < s.nstr; i++) begin
            len = (s.lim_bad == 3 && i == 0) ? 64'($urandom_range(513, 65535))
                                             : 64'($urandom_range(0, 8));
            put_le(blob, len, 2);
            put_rand(blob, (len > STR_MAX) ? 2 : len);
          end
          put_rand(blob, s.leftover);
        end
      end
      elen = blob.size() + s.ext_skew;
      if (elen < 0) elen = 0;
      if (s.ext_forced) elen = s.ext_force;
      put_le(q, elen, 2);
      foreach (blob[i]) q.insert(q.size(), blob[i]);
    end
    put_le(q, s.blocks, 8);
    put_rand(q, 4);
    put_le(q, s.payload, 8);
    size = HDR_LEN + s.nlen + TAIL_BYTES + MAC_BYTES + s.payload + s.blocks * 16;
    if (s.ver == VER_2) size += 2 + elen;
    if (s.cut == -2) q = q[0 : $urandom_range(0, q.size() - 2)];
    else if (s.cut >= 0 && s.cut < q.size()) q = q[0 : s.cut];
    if (s.drop > 0) q = q[0 : q.size() - 1 - s.drop];
    put_rand(q, s.junk);
  endfunction

  function automatic shape_t directed_shape(int i);
    shape_t s;
    s = clean_shape();
    s.ver = VER_2; s.nlen = 4; s.auth = ~pwd_now; s.nstr = 1; s.blob_len = -1;
    case (i)
      0:  begin s.ver = VER_1; s.nlen = 0; end
      1:  s.blob_len = 0;
      2:  begin s.nlen = NAME_MAX; s.auth = pwd_now; s.nstr = 3; s.leftover = 2; end
      3:  s.nlen = NAME_MAX + 1;
      4:  s.magic_bad = 1;
      5:  s.ver = 16'h0000;
      6:  s.ver = 16'hFFFF;
      7:  s.hlen_bad = 1;
      8:  begin s.ext_forced = 1; s.ext_force = EXT_MAX + 1; end
      9:  begin s.auth = pwd_now; s.blob_len = EXT_MAX; end
      10: s.cred_cut = 1;
      11: s.blob_len = EXT_MIN_CRED - 1;
      12: s.lim_bad = 1;
      13: s.lim_bad = 2;
      14: s.lim_bad = 3;
      15: s.payload = '1;
      16: s.blocks = '1;
      17: s.cut = 3;
      18: begin s.nlen = 10; s.cut = HDR_LEN + 4; end
      19: begin s.nlen = 0; s.cut = HDR_LEN + 4; end
      20: s.drop = 5;
      21: s.noise_len = 1;
      default: begin s.auth = pwd_now; s.nstr = 4; s.junk = 3; end
    endcase
    return s;
  endfunction

  function automatic shape_t random_shape();
    shape_t s;
    s = clean_shape();
    if ($urandom_range(0, 99) < 35) begin
      s.noise_len = $urandom_range(1, 30);
      return s;
    end
    s.junk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if ($urandom_range(0, 99) < 45) return s;
    case ($urandom_range(0, 11))
      0:  s.magic_bad = 1;
      1:  s.ver = $urandom_range(0, 65535);
      2:  s.hlen_bad = 1;
      3:  s.nlen = $urandom_range(NAME_MAX + 1, 65535);
      4:  begin s.ver = VER_2; s.ext_forced = 1; s.ext_force = $urandom_range(0, 65535); end
      5:  begin s.ver = VER_2; s.lim_bad = $urandom_range(1, 3); s.nstr = 1; s.auth = ~pwd_now; end
      6:  begin s.ver = VER_2; s.cred_cut = 1; s.auth = ~pwd_now; s.blob_len = -1; end
      7:  begin s.ver = VER_2; s.auth = ~pwd_now; s.blob_len = $urandom_range(1, 4); end
      8:  begin s.ver = VER_2; s.blob_len = -1; s.ext_skew = $urandom_range(0, 6) - 3; end
      9:  begin
        s.payload = $urandom_range(0, 1) ? {$urandom, $urandom} : '1;
        s.blocks = {$urandom, $urandom};
      end
      10: s.cut = -2;
      default: begin s.ver = VER_2; s.blob_len = $urandom_range(5, 60); end
    endcase
    return s;
  endfunction

  // One phase: idle, set registers, then run a batch of containers
  task automatic run_phase(int idx, bit directed, int count);
    shape_t s;
    logic [7:0] q[$];
    logic [63:0] size;
    logic [62:0] flen;
    wait_drained();
    pwd_now = (idx == 0) ? 8'h00 : (idx == 1) ? 8'hFF : 8'($urandom_range(0, 255));
    s = directed ? directed_shape(idx) : clean_shape();
    build(s, q, size);
    if (idx == 2) flen = '1;
    else if (idx == 3) flen = '0;
    else if (!directed && $urandom_range(0, 3) == 0) flen = {$urandom, $urandom};
    else flen = size[62:0];
    cfg_write(CFG_PWD_CODE, {55'b0, pwd_now});
    cfg_write(CFG_FILE_LEN, flen);
    send_stream(q);
    for (int i = 1; i < count; i++) begin
      s = random_shape();
      build(s, q, size);
      send_stream(q);
    end
  endtask

  initial begin
    int results;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed containers, one per phase so each can be set to match
    for (int i = 0; i < 23; i++) begin
      send_idle_pct = (i % 3 == 0) ? 0 : 30;
      recv_stall_pct = (i % 4 == 0) ? 0 : 40;
      run_phase(i, 1, 1);
    end

    // random phases until enough containers have been checked
    results = 0;
    for (int p = 0; results < RAND_RESULTS; p++) begin
      send_idle_pct = (p % 4 == 0) ? 0 : $urandom_range(5, 50);
      recv_stall_pct = (p % 5 == 0) ? 0 : $urandom_range(5, 70);
      if (p == 3) begin
        // long receiver hold-off while short streams keep arriving
        send_idle_pct = 0;
        hold_req = 1;
        run_phase(4, 0, 1);
        for (int i = 0; i < 8; i++) begin
          shape_t s;
          logic [7:0] q[$];
          logic [63:0] size;
          s = clean_shape();
          s.noise_len = $urandom_range(1, 8);
          build(s, q, size);
          send_stream(q);
        end
        results += 9;
      end else begin
        int n;
        n = $urandom_range(2, 5);
        run_phase(4 + p, 0, n);
        results += n;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
